### rtl/tpkd_pkg.sv
// ----------------------------------------------------------------------------
// tpkd_pkg
// Shared types and constants for the touch packet key decoder.
// ----------------------------------------------------------------------------
package tpkd_pkg;

    // Packet header codes
    localparam logic [7:0] HDR_REPORT = 8'h5A;
    localparam logic [7:0] HDR_HELLO  = 8'h55;

    // Reset value of the Y mirror base
    localparam logic [11:0] Y_BASE_RESET = 12'd1088;

    // Configuration register indexes
    localparam logic [1:0] CFG_BOARD_VARIANT = 2'd0;
    localparam logic [1:0] CFG_Y_MIRROR_BASE = 2'd1;

    // Board variants
    localparam logic [1:0] VAR_OTHER  = 2'd0;
    localparam logic [1:0] VAR_FIRST  = 2'd1;
    localparam logic [1:0] VAR_SECOND = 2'd2;

    // Virtual button codes (status byte bits 7..3)
    localparam logic [4:0] BTN_NONE = 5'd0;
    localparam logic [4:0] BTN_A    = 5'd2;
    localparam logic [4:0] BTN_B    = 5'd4;
    localparam logic [4:0] BTN_C    = 5'd8;
    localparam logic [4:0] BTN_D    = 5'd16;

    typedef enum logic [2:0] {
        CLS_OTHER   = 3'd0,
        CLS_HELLO   = 3'd1,
        CLS_TOUCH   = 3'd2,
        CLS_PRESS   = 3'd3,
        CLS_RELEASE = 3'd4,
        CLS_NONE    = 3'd5
    } class_t;

    typedef enum logic [2:0] {
        KC_NONE   = 3'd0,
        KC_BACK   = 3'd1,
        KC_MENU   = 3'd2,
        KC_HOME   = 3'd3,
        KC_SEARCH = 3'd4
    } key_t;

    // One incoming packet
    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] packet_byte1;
        logic [7:0] packet_byte2;
        logic [7:0] packet_byte3;
        logic [7:0] packet_byte4;
        logic [7:0] packet_byte5;
        logic [7:0] packet_byte6;
        logic [7:0] packet_byte7;
        logic [7:0] status_byte;
    } packet_t;

    // Key and pen flags carried from packet to packet
    typedef struct packed {
        logic back_held;
        logic menu_held;
        logic home_held;
        logic search_held;
        logic pen_lifted;
    } flags_t;

    // One decoded result
    typedef struct packed {
        class_t      packet_class;
        logic        contact_one_down;
        logic [11:0] contact_one_x;
        logic [11:0] contact_one_y;
        logic        contact_two_down;
        logic [11:0] contact_two_x;
        logic [11:0] contact_two_y;
        logic        lift_before_key;
        key_t        key_code;
        logic        key_down;
    } result_t;

endpackage

### rtl/tpkd_decode.sv
// ----------------------------------------------------------------------------
// tpkd_decode
// Decodes one packet against the current key/pen flags: classifies it,
// extracts and mirrors the contacts, maps buttons to keys and works out the
// next flags.
// ----------------------------------------------------------------------------
module tpkd_decode
    import tpkd_pkg::*;
(
    input  packet_t     pkt,
    input  flags_t      flags,
    input  logic [1:0]  board_variant,
    input  logic [11:0] y_mirror_base,
    output result_t     res,
    output flags_t      flags_next
);

    logic [11:0] y1_raw;
    logic [11:0] y2_raw;
    logic [4:0]  btn;
    logic        any_held;
    logic        var_remap;
    logic        press;
    key_t        press_key;

    // |base - raw| on 12 bits
    function automatic logic [11:0] mirror(input logic [11:0] base, input logic [11:0] raw);
        logic [11:0] d;
        begin
            d = (base >= raw) ? (base - raw) : (raw - base);
            return d;
        end
    endfunction

    assign y1_raw    = {pkt.packet_byte1[3:0], pkt.packet_byte3};
    assign y2_raw    = {pkt.packet_byte4[3:0], pkt.packet_byte6};
    assign btn       = pkt.status_byte[7:3];
    assign any_held  = flags.back_held | flags.menu_held | flags.home_held | flags.search_held;
    assign var_remap = (board_variant == VAR_FIRST) || (board_variant == VAR_SECOND);

    // Button to key mapping; press only if the button's own flag is clear
    always_comb
    begin
        press     = 1'b0;
        press_key = KC_NONE;
        if ((btn == BTN_A) && !flags.back_held)
        begin
            press     = 1'b1;
            press_key = var_remap ? KC_MENU : KC_BACK;
        end
        else if ((btn == BTN_B) && !flags.menu_held)
        begin
            press     = 1'b1;
            press_key = var_remap ? KC_HOME : KC_MENU;
        end
        else if ((btn == BTN_C) && !flags.home_held)
        begin
            press = 1'b1;
            case (board_variant)
                VAR_FIRST:  press_key = KC_SEARCH;
                VAR_SECOND: press_key = KC_BACK;
                default:    press_key = KC_HOME;
            endcase
        end
        else if ((btn == BTN_D) && !flags.search_held)
        begin
            press     = 1'b1;
            press_key = (board_variant == VAR_FIRST) ? KC_BACK : KC_SEARCH;
        end
    end

    // Classification, result fields and flag update
    always_comb
    begin
        res        = '0;
        flags_next = flags;
        if (pkt.header_byte != HDR_REPORT)
        begin
            if ((pkt.header_byte == HDR_HELLO) && (pkt.packet_byte1 == HDR_HELLO) &&
                (pkt.packet_byte2 == HDR_HELLO) && (pkt.packet_byte3 == HDR_HELLO))
                res.packet_class = CLS_HELLO;
            else
                res.packet_class = CLS_OTHER;
        end
        else if ((btn == BTN_NONE) && !any_held)
        begin
            // touch report; finger count is status bits 7..1
            res.packet_class     = CLS_TOUCH;
            res.contact_one_down = (pkt.status_byte[7:1] != 7'd0);
            res.contact_one_x    = {pkt.packet_byte1[7:4], pkt.packet_byte2};
            res.contact_one_y    = mirror(y_mirror_base, y1_raw);
            res.contact_two_down = (pkt.status_byte[7:2] != 6'd0);
            res.contact_two_x    = {pkt.packet_byte4[7:4], pkt.packet_byte5};
            res.contact_two_y    = mirror(y_mirror_base, y2_raw);
            flags_next.pen_lifted = (pkt.status_byte[7:1] == 7'd0);
        end
        else if (btn == BTN_NONE)
        begin
            // release the first held key in priority order
            res.packet_class = CLS_RELEASE;
            res.key_down     = 1'b0;
            if (flags.back_held)
                res.key_code = KC_BACK;
            else if (flags.menu_held)
                res.key_code = KC_MENU;
            else if (flags.home_held)
                res.key_code = KC_HOME;
            else
                res.key_code = KC_SEARCH;
            flags_next.back_held   = 1'b0;
            flags_next.menu_held   = 1'b0;
            flags_next.home_held   = 1'b0;
            flags_next.search_held = 1'b0;
        end
        else if (press)
        begin
            res.packet_class      = CLS_PRESS;
            res.lift_before_key   = !flags.pen_lifted;
            res.key_code          = press_key;
            res.key_down          = 1'b1;
            flags_next.pen_lifted = 1'b1;
            case (press_key)
                KC_BACK:    flags_next.back_held   = 1'b1;
                KC_MENU:    flags_next.menu_held   = 1'b1;
                KC_HOME:    flags_next.home_held   = 1'b1;
                default:    flags_next.search_held = 1'b1;
            endcase
        end
        else
        begin
            res.packet_class = CLS_NONE;
        end
    end

endmodule

### rtl/touch_packet_key_decoder.sv
// ----------------------------------------------------------------------------
// touch_packet_key_decoder
// Decodes 9-byte touch controller packets into touch reports and virtual key
// press/release events.
// ----------------------------------------------------------------------------
// One packet per clock is sustained while the output is not stalled: a
// packet accepted on the input is loaded into the input register, decoded
// there, and its result is loaded into the result register, which offers it
// on the output. Both registers move on together whenever the result
// register is empty or being taken, so a stall on the output holds the input
// register and then the input. Each packet yields exactly one result. The key
// and pen flags are updated as the result is registered, so back-to-back
// packets see each other's effect in order. Configuration (board variant, Y
// mirror base) is always ready and should only be written while no packet is
// in flight.
// ----------------------------------------------------------------------------
module touch_packet_key_decoder
    import tpkd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  header_byte,
    input  logic [7:0]  packet_byte1,
    input  logic [7:0]  packet_byte2,
    input  logic [7:0]  packet_byte3,
    input  logic [7:0]  packet_byte4,
    input  logic [7:0]  packet_byte5,
    input  logic [7:0]  packet_byte6,
    input  logic [7:0]  packet_byte7,
    input  logic [7:0]  status_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  packet_class,
    output logic        contact_one_down,
    output logic [11:0] contact_one_x,
    output logic [11:0] contact_one_y,
    output logic        contact_two_down,
    output logic [11:0] contact_two_x,
    output logic [11:0] contact_two_y,
    output logic        lift_before_key,
    output logic [2:0]  key_code,
    output logic        key_down,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    logic        s1_valid_reg;
    packet_t     s1_pkt_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;
    flags_t      flags_reg;
    logic [1:0]  variant_reg;
    logic [11:0] base_reg;

    logic        advance;
    logic        load_in;
    logic        commit;
    result_t     res_next;
    flags_t      flags_next;
    packet_t     in_pkt;

    // Pipeline control
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign load_in  = !in_stall;
    assign commit   = advance && s1_valid_reg;

    assign in_pkt = '{header_byte:  header_byte,
                      packet_byte1: packet_byte1,
                      packet_byte2: packet_byte2,
                      packet_byte3: packet_byte3,
                      packet_byte4: packet_byte4,
                      packet_byte5: packet_byte5,
                      packet_byte6: packet_byte6,
                      packet_byte7: packet_byte7,
                      status_byte:  status_byte};

    // Decode
    tpkd_decode u_decode
    (
        .pkt           (s1_pkt_reg),
        .flags         (flags_reg),
        .board_variant (variant_reg),
        .y_mirror_base (base_reg),
        .res           (res_next),
        .flags_next    (flags_next)
    );

    // Control state, flags and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
            variant_reg   <= VAR_OTHER;
            base_reg      <= Y_BASE_RESET;
        end
        else
        begin
            if (load_in)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (commit)
                flags_reg <= flags_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BOARD_VARIANT: variant_reg <= cfg_data[1:0];
                    CFG_Y_MIRROR_BASE: base_reg    <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (load_in && in_valid)
            s1_pkt_reg <= in_pkt;
        if (commit)
            out_res_reg <= res_next;
    end

    // Outputs
    assign cfg_ready        = 1'b1;
    assign out_valid        = out_valid_reg;
    assign packet_class     = out_res_reg.packet_class;
    assign contact_one_down = out_res_reg.contact_one_down;
    assign contact_one_x    = out_res_reg.contact_one_x;
    assign contact_one_y    = out_res_reg.contact_one_y;
    assign contact_two_down = out_res_reg.contact_two_down;
    assign contact_two_x    = out_res_reg.contact_two_x;
    assign contact_two_y    = out_res_reg.contact_two_y;
    assign lift_before_key  = out_res_reg.lift_before_key;
    assign key_code         = out_res_reg.key_code;
    assign key_down         = out_res_reg.key_down;

`ifndef SYNTHESIS
    // input only held back while a packet waits in the input register
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty input register");

    // a press always names a key and is marked down
    a_press_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.packet_class == CLS_PRESS)) |->
        (out_res_reg.key_down && (out_res_reg.key_code != KC_NONE)))
        else $error("key press without key");

    // a release always names a key and is marked up
    a_release_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_res_reg.packet_class == CLS_RELEASE)) |->
        (!out_res_reg.key_down && (out_res_reg.key_code != KC_NONE)))
        else $error("key release without key");

    // a committed release clears every held key
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (res_next.packet_class == CLS_RELEASE)) |=>
        (!flags_reg.back_held && !flags_reg.menu_held &&
         !flags_reg.home_held && !flags_reg.search_held))
        else $error("held flags survive a release");

    // a committed press leaves the pen lifted
    a_press_lifts_pen: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (res_next.packet_class == CLS_PRESS)) |=> flags_reg.pen_lifted)
        else $error("pen not lifted after key press");
`endif

endmodule
